/* hw/rtl/usbkbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbkbd_pkg
// Shared types, codes and helpers of the USB keyboard report sequencer.
// ----------------------------------------------------------------------------
package usbkbd_pkg;

  localparam int unsigned NumCfgKeys = 6;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_CLOSE = 2'd1,
    REQ_DELAY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_LEFT_SHIFT  = 3'd0,
    CFG_RIGHT_SHIFT = 3'd1,
    CFG_LEFT_CTRL   = 3'd2,
    CFG_RIGHT_CTRL  = 3'd3,
    CFG_LEFT_ALT    = 3'd4,
    CFG_RIGHT_ALT   = 3'd5,
    CFG_DELAY_THR   = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]  ReleasePrefix   = 8'hF0;
  localparam logic [23:0] DelayThrDefault = 24'd30000;
  // usages E0..E7 share these upper bits
  localparam logic [4:0]  ModUsageHigh    = 5'b11100;

  // hid modifier bit for each configured key register, in register order
  localparam logic [NumCfgKeys-1:0][2:0] CfgModBit = {
    3'd6, 3'd2, 3'd4, 3'd0, 3'd5, 3'd1
  };

  typedef logic [NumCfgKeys-1:0][7:0] cfg_keys_t;

  typedef struct packed {
    logic [7:0] report_scan;
    logic [7:0] report_mods;
    logic       all_keys_up;
    logic       wait_done;
    logic       last_of_run;
  } out_item_t;

  // first matching register wins, then usages E0..E7
  function automatic logic [7:0] match_modifier(input logic [7:0] code,
                                                input logic [7:0] key_num,
                                                input cfg_keys_t  cfg_keys);
    logic [7:0] bit_mask;
    bit_mask = 8'h00;
    if (code[7:3] == ModUsageHigh) begin
      bit_mask = 8'h01 << code[2:0];
    end
    for (int i = NumCfgKeys - 1; i >= 0; i--) begin
      if (key_num == cfg_keys[i]) begin
        bit_mask = 8'h01 << CfgModBit[i];
      end
    end
    return bit_mask;
  endfunction

endpackage

/* hw/rtl/usbkbd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbkbd_if
// Valid/ready channels of the USB keyboard report sequencer.
// ----------------------------------------------------------------------------
interface usbkbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  key_code;
  logic        is_modifier;
  logic        is_sequence;
  logic [7:0]  key_number;
  logic [23:0] delay_us;

  modport source (output valid, req_type, key_code, is_modifier, is_sequence,
                  key_number, delay_us, input ready);
  modport sink (input valid, req_type, key_code, is_modifier, is_sequence,
                key_number, delay_us, output ready);
endinterface

interface usbkbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_scan;
  logic [7:0] report_mods;
  logic       all_keys_up;
  logic       wait_done;
  logic       last_of_run;

  modport source (output valid, report_scan, report_mods, all_keys_up, wait_done,
                  last_of_run, input ready);
  modport sink (input valid, report_scan, report_mods, all_keys_up, wait_done,
                last_of_run, output ready);
endinterface

interface usbkbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/usb_keyboard_report_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_keyboard_report_sequencer
// Converts keyboard-wedge items into USB HID boot keyboard reports.
// ----------------------------------------------------------------------------
// An input transaction is taken into an input register and then decoded in a
// single pass that updates the modifier state and loads between zero and three
// reports into a three-entry result buffer. The buffer drives the output port
// and sends one report per cycle while the output is ready; each item passes
// through the input register before its reports reach the buffer. Items that
// produce no report pass at one per cycle while the buffer is empty. After an
// item that produces reports, the next item is held in the input register until
// the buffer is down to its last entry and that entry is taken (single output).
// Configuration writes are always taken and must only occur while idle.
module usb_keyboard_report_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  usbkbd_cfg_if.sink   cfg_i,
  usbkbd_in_if.sink    in_i,
  usbkbd_out_if.source out_o
);

  // configuration
  usbkbd_pkg::cfg_keys_t cfg_keys_q;
  logic [23:0]           delay_thr_q;

  // input register
  logic        stg_vld_q;
  logic [1:0]  stg_req_q;
  logic [7:0]  stg_code_q;
  logic        stg_mod_q;
  logic        stg_seq_q;
  logic [7:0]  stg_knum_q;
  logic [23:0] stg_delay_q;

  // sequencer state
  logic [7:0] pend_scan_q, pend_scan_d;
  logic [7:0] mod_mask_q, mod_mask_d;
  logic [7:0] kept_mods_q, kept_mods_d;
  logic       next_rel_q, next_rel_d;
  logic [7:0] sent_scan_q, sent_scan_d;
  logic [7:0] sent_mods_q, sent_mods_d;

  // result buffer
  usbkbd_pkg::out_item_t res_q [3];
  usbkbd_pkg::out_item_t res_d [3];
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            num_res;

  logic pop;
  logic stg_load;
  logic in_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_keys_q  <= '0;
      delay_thr_q <= usbkbd_pkg::DelayThrDefault;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        usbkbd_pkg::CFG_LEFT_SHIFT:  cfg_keys_q[0] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_RIGHT_SHIFT: cfg_keys_q[1] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_LEFT_CTRL:   cfg_keys_q[2] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_RIGHT_CTRL:  cfg_keys_q[3] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_LEFT_ALT:    cfg_keys_q[4] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_RIGHT_ALT:   cfg_keys_q[5] <= cfg_i.data[7:0];
        usbkbd_pkg::CFG_DELAY_THR:   delay_thr_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pop      = out_o.valid && out_o.ready;
  assign stg_load = stg_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_i.ready = !stg_vld_q || stg_load;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_req_q   <= in_i.req_type;
      stg_code_q  <= in_i.key_code;
      stg_mod_q   <= in_i.is_modifier;
      stg_seq_q   <= in_i.is_sequence;
      stg_knum_q  <= in_i.key_number;
      stg_delay_q <= in_i.delay_us;
    end
  end

  // single-pass decode of the staged item
  always_comb begin
    logic [7:0]            mbit;
    logic [7:0]            mask_new;
    logic                  gap_en;
    logic                  rel_en;
    logic [7:0]            s_mods;
    usbkbd_pkg::out_item_t ra;
    usbkbd_pkg::out_item_t rb;
    usbkbd_pkg::out_item_t rc;

    mbit        = usbkbd_pkg::match_modifier(stg_code_q, stg_knum_q, cfg_keys_q);
    mask_new    = mod_mask_q;
    gap_en      = 1'b0;
    rel_en      = 1'b0;
    s_mods      = sent_mods_q;
    pend_scan_d = pend_scan_q;
    mod_mask_d  = mod_mask_q;
    kept_mods_d = kept_mods_q;
    next_rel_d  = next_rel_q;
    sent_scan_d = sent_scan_q;
    sent_mods_d = sent_mods_q;
    num_res     = 2'd0;
    ra          = '{report_scan: 8'h00, report_mods: kept_mods_q, all_keys_up: 1'b0,
                    wait_done: 1'b1, last_of_run: 1'b0};
    rb          = '{report_scan: 8'h00, report_mods: mod_mask_q, all_keys_up: 1'b0,
                    wait_done: 1'b1, last_of_run: 1'b0};
    rc          = '{report_scan: stg_code_q, report_mods: mod_mask_q, all_keys_up: 1'b0,
                    wait_done: 1'b1, last_of_run: 1'b1};

    case (usbkbd_pkg::req_type_e'(stg_req_q))
      usbkbd_pkg::REQ_CLOSE: begin
        pend_scan_d = 8'h00;
        mod_mask_d  = 8'h00;
        sent_scan_d = 8'h00;
        sent_mods_d = 8'h00;
        rc          = '{report_scan: 8'h00, report_mods: 8'h00, all_keys_up: 1'b1,
                        wait_done: 1'b1, last_of_run: 1'b1};
        num_res     = 2'd1;
      end
      usbkbd_pkg::REQ_DELAY: begin
        if (stg_delay_q > delay_thr_q) begin
          sent_scan_d = 8'h00;
          sent_mods_d = mod_mask_q;
          rc          = '{report_scan: 8'h00, report_mods: mod_mask_q, all_keys_up: 1'b0,
                          wait_done: 1'b0, last_of_run: 1'b1};
          num_res     = 2'd1;
        end
      end
      usbkbd_pkg::REQ_KEY: begin
        if (next_rel_q) begin
          next_rel_d = 1'b0;
          if (mbit != 8'h00) begin
            mask_new    = mod_mask_q & ~mbit;
            mod_mask_d  = mask_new;
            kept_mods_d = mask_new;
          end
        end else if (stg_code_q == usbkbd_pkg::ReleasePrefix) begin
          next_rel_d = 1'b1;
        end else if ((stg_mod_q || stg_seq_q) && (mbit != 8'h00)) begin
          mod_mask_d = mod_mask_q | mbit;
        end else begin
          pend_scan_d = stg_code_q;
          rel_en      = (kept_mods_q != sent_mods_q);
          if (rel_en) begin
            s_mods = kept_mods_q;
          end
          // sent scan is zero after a release report
          gap_en = ((stg_code_q == (rel_en ? 8'h00 : sent_scan_q)) &&
                    (stg_code_q != 8'h00)) || (mod_mask_q != s_mods);
          sent_scan_d = stg_code_q;
          sent_mods_d = mod_mask_q;
          kept_mods_d = mod_mask_q;
          num_res     = 2'd1 + 2'(rel_en) + 2'(gap_en);
        end
      end
      default: ;
    endcase

    res_d[0] = rc;
    res_d[1] = rc;
    res_d[2] = rc;
    if (rel_en) begin
      res_d[0] = ra;
      if (gap_en) begin
        res_d[1] = rb;
      end
    end else if (gap_en) begin
      res_d[0] = rb;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (stg_load) begin
      cnt_d = num_res;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 2'd0;
      pend_scan_q <= 8'h00;
      mod_mask_q  <= 8'h00;
      kept_mods_q <= 8'h00;
      next_rel_q  <= 1'b0;
      sent_scan_q <= 8'h00;
      sent_mods_q <= 8'h00;
    end else begin
      cnt_q <= cnt_d;
      if (stg_load) begin
        pend_scan_q <= pend_scan_d;
        mod_mask_q  <= mod_mask_d;
        kept_mods_q <= kept_mods_d;
        next_rel_q  <= next_rel_d;
        sent_scan_q <= sent_scan_d;
        sent_mods_q <= sent_mods_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_load) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.report_scan = res_q[0].report_scan;
  assign out_o.report_mods = res_q[0].report_mods;
  assign out_o.all_keys_up = res_q[0].all_keys_up;
  assign out_o.wait_done   = res_q[0].wait_done;
  assign out_o.last_of_run = res_q[0].last_of_run;

`ifndef SYNTHESIS
  a_load_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_load |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))
    else $error("result buffer reloaded while reports remain");

  a_results_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_load && (num_res != 2'd0)) |=> out_o.valid)
    else $error("decoded reports not presented");

  a_last_entry_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> res_q[0].last_of_run)
    else $error("final buffered report lacks last_of_run");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_load && (stg_req_q == usbkbd_pkg::REQ_CLOSE)) |=>
      (mod_mask_q == 8'h00) && (pend_scan_q == 8'h00))
    else $error("close did not clear key state");
`endif

endmodule
